### rtl/msb_first_bit_reader_vbr_top_macros.svh
// Assertion helpers for the bit reader.
`ifndef MSB_FIRST_BIT_READER_VBR_TOP_MACROS_SVH
`define MSB_FIRST_BIT_READER_VBR_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define MBRV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MBRV_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mbrv_pkg.sv
`timescale 1ns / 1ps

package mbrv_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int QH_W          = $clog2(QUEUE_DEPTH);
	localparam int QC_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int VALUE_W       = 64;
	localparam int NARROW_W      = 32;
	localparam int VBR_MAX_CHUNK = 32;
	localparam int SHIFT_W       = $clog2(VALUE_W + 1);
	localparam int CMDQ_DEPTH    = 2;
	localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);
	localparam int IN_DATA_W     = 24;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_READ = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_FIXED = 2'd0,
		MODE_UVBR  = 2'd1,
		MODE_SVBR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_EOS = 2'd1,
		STAT_BAD = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ADV,
		BK_FETCH,
		BK_CHUNK,
		BK_FINISH,
		BK_EMIT
	} bk_state_t;

	// Decoded transaction handed from front to back.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;   // byte right-aligned to its valid bits
		logic [3:0]  nbits;  // 1..8
		mode_t       mode;
		logic [6:0]  width;
		logic        wide;
		logic        ok;     // static width/mode check passed
	} cmd_t;

	typedef struct packed {
		logic [3:0] nbits;
		logic [7:0] data;
	} qent_t;

	function automatic logic [VALUE_W-1:0] low_mask(input logic [SHIFT_W-1:0] w);
		logic [VALUE_W-1:0] m;
		if (w >= SHIFT_W'(VALUE_W)) begin
			m = '1;
		end else begin
			m = (VALUE_W'(1) << w) - VALUE_W'(1);
		end
		return m;
	endfunction

endpackage

### rtl/mbrv_front.sv
`timescale 1ns / 1ps

module mbrv_front import mbrv_pkg::*; (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // byte_value, byte_bits, read_mode, read_width, wide_result
	input  logic [1:0]           s_tuser,   // kind
	output logic                 push_valid,
	input  logic                 push_ready,
	output cmd_t                 push_cmd
);

	logic [7:0] byte_value;
	logic [3:0] byte_bits;
	logic [3:0] nbits;
	logic [1:0] read_mode;
	logic [6:0] read_width;
	logic       wide_result;
	logic [6:0] res_w;
	logic       ok;
	logic       keep;

	assign byte_value  = s_tdata[7:0];
	assign byte_bits   = s_tdata[11:8];
	assign read_mode   = s_tdata[13:12];
	assign read_width  = s_tdata[20:14];
	assign wide_result = s_tdata[21];

	assign nbits = (byte_bits > 4'd8) ? 4'd8 : byte_bits;
	assign res_w = wide_result ? 7'(VALUE_W) : 7'(NARROW_W);

	always_comb begin
		unique case (mode_t'(read_mode))
			MODE_FIXED: ok = (read_width >= 7'd1) && (read_width <= res_w);
			MODE_UVBR, MODE_SVBR:
				ok = (read_width >= 7'd2) && (read_width <= 7'(VBR_MAX_CHUNK));
			default:    ok = 1'b0;
		endcase
	end

	// Zero-bit bytes and unknown kinds change nothing; they are dropped here.
	always_comb begin
		unique case (kind_t'(s_tuser))
			KIND_BYTE: keep = (nbits != 4'd0);
			KIND_READ: keep = 1'b1;
			KIND_END:  keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	always_comb begin
		push_cmd.kind  = kind_t'(s_tuser);
		push_cmd.data  = byte_value >> (4'd8 - nbits);
		push_cmd.nbits = nbits;
		push_cmd.mode  = mode_t'(read_mode);
		push_cmd.width = read_width;
		push_cmd.wide  = wide_result;
		push_cmd.ok    = ok;
	end

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid & keep;

endmodule

### rtl/mbrv_cmdq.sv
`timescale 1ns / 1ps

module mbrv_cmdq import mbrv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = (cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
					wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
					rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CMDQ_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CMDQ_CNT_W'(1);
			end
		end
	end

endmodule

### rtl/mbrv_back.sv
`timescale 1ns / 1ps

module mbrv_back import mbrv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  cmd_t               pop_cmd,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,   // value
	output logic [1:0]         m_tuser    // status
);

	localparam int TS_W = QC_W + 1;

	bk_state_t state_q, state_d;

	qent_t            mem [QUEUE_DEPTH];
	qent_t            rd_q;
	logic [QH_W-1:0]  head_q;
	logic [QC_W-1:0]  count_q;
	logic [7:0]       cur_q;
	logic [3:0]       bleft_q;
	logic             ended_q;

	logic               req_q;
	mode_t              mode_q;
	logic [6:0]         width_q;
	logic               wide_q;
	logic [VALUE_W-1:0] acc_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [31:0]        chunk_q;
	logic [6:0]         need_q;
	logic               sign_q;

	logic [VALUE_W-1:0] res_value_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	status_t            out_status_q;

	logic               avail;
	logic [3:0]         bl_dec;
	logic               bit_in;
	logic [TS_W-1:0]    tail_sum;
	logic [QH_W-1:0]    tail;
	logic               q_full;
	logic               mem_we;
	logic [QH_W-1:0]    head_inc;
	logic [SHIFT_W-1:0] d7;
	logic [4:0]         d5;
	logic [VALUE_W-1:0] d_mask;
	logic [31:0]        chunk_data;
	logic               more;
	logic [VALUE_W-1:0] placed;
	logic [SHIFT_W:0]   shift_sum;
	logic [SHIFT_W-1:0] shift_new;
	logic [VALUE_W-1:0] ext;
	logic [VALUE_W-1:0] rw_mask;
	logic               emit_ok;
	logic               bad_req;

	assign avail    = (bleft_q != 4'd0) || (count_q != '0);
	assign bl_dec   = bleft_q - 4'd1;
	assign bit_in   = cur_q[bl_dec[2:0]];
	assign tail_sum = TS_W'(head_q) + TS_W'(count_q);
	assign tail     = (tail_sum >= TS_W'(QUEUE_DEPTH)) ?
		QH_W'(tail_sum - TS_W'(QUEUE_DEPTH)) : QH_W'(tail_sum);
	assign q_full   = (count_q == QC_W'(QUEUE_DEPTH));
	assign head_inc = (head_q == QH_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QH_W'(1);
	assign mem_we   = (state_q == BK_IDLE) && pop_valid && (pop_cmd.kind == KIND_BYTE) &&
		!ended_q && !q_full;
	assign bad_req  = !pop_cmd.ok || req_q;

	// Chunk retire: data bits below the continuation flag.
	assign d7         = width_q - 7'd1;
	assign d5         = d7[4:0];
	assign d_mask     = low_mask(d7);
	assign chunk_data = chunk_q & d_mask[31:0];
	assign more       = chunk_q[d5];
	assign placed     = {{(VALUE_W-32){1'b0}}, chunk_data} << shift_q[SHIFT_W-2:0];
	assign shift_sum  = {1'b0, shift_q} + {1'b0, d7};
	assign shift_new  = (shift_sum > (SHIFT_W+1)'(VALUE_W)) ? SHIFT_W'(VALUE_W) :
		shift_sum[SHIFT_W-1:0];

	// Final result: sign extension above the last shift, then result width.
	assign rw_mask = wide_q ? '1 : low_mask(SHIFT_W'(NARROW_W));
	assign ext     = ((mode_q == MODE_SVBR) && sign_q &&
		(shift_q < (wide_q ? SHIFT_W'(VALUE_W) : SHIFT_W'(NARROW_W)))) ?
		~low_mask(shift_q) : '0;

	assign emit_ok   = !out_valid_q || m_tready;
	assign pop_ready = (state_q == BK_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					unique case (pop_cmd.kind)
						KIND_READ: state_d = bad_req ? BK_EMIT : BK_ADV;
						default:   state_d = BK_ADV;
					endcase
				end
			end
			BK_ADV: begin
				if (!req_q) begin
					state_d = BK_IDLE;
				end else if (!avail) begin
					state_d = ended_q ? BK_EMIT : BK_IDLE;
				end else if (bleft_q == 4'd0) begin
					state_d = BK_FETCH;
				end else if (need_q == 7'd1) begin
					state_d = (mode_q == MODE_FIXED) ? BK_FINISH : BK_CHUNK;
				end
			end
			BK_FETCH:  state_d = BK_ADV;
			BK_CHUNK:  state_d = more ? BK_ADV : BK_FINISH;
			BK_FINISH: state_d = BK_EMIT;
			BK_EMIT:   state_d = emit_ok ? BK_IDLE : BK_EMIT;
			default:   state_d = BK_IDLE;
		endcase
	end

	// Byte store: one write port at the tail, registered read at the head.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail] <= '{nbits: pop_cmd.nbits, data: pop_cmd.data};
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			cur_q        <= '0;
			bleft_q      <= '0;
			ended_q      <= 1'b0;
			req_q        <= 1'b0;
			mode_q       <= MODE_FIXED;
			width_q      <= '0;
			wide_q       <= 1'b0;
			acc_q        <= '0;
			shift_q      <= '0;
			chunk_q      <= '0;
			need_q       <= '0;
			sign_q       <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= STAT_OK;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop_valid) begin
						case (pop_cmd.kind)
							KIND_BYTE: begin
								if (mem_we) begin
									count_q <= count_q + QC_W'(1);
								end
							end
							KIND_END: ended_q <= 1'b1;
							KIND_READ: begin
								if (bad_req) begin
									res_value_q  <= '0;
									res_status_q <= STAT_BAD;
								end else begin
									req_q   <= 1'b1;
									mode_q  <= pop_cmd.mode;
									width_q <= pop_cmd.width;
									wide_q  <= pop_cmd.wide;
									acc_q   <= '0;
									shift_q <= '0;
									chunk_q <= '0;
									need_q  <= pop_cmd.width;
								end
							end
							default: ;
						endcase
					end
				end
				BK_ADV: begin
					if (req_q && avail && (bleft_q != 4'd0)) begin
						bleft_q <= bl_dec;
						need_q  <= need_q - 7'd1;
						if (mode_q == MODE_FIXED) begin
							acc_q <= {acc_q[VALUE_W-2:0], bit_in};
						end else begin
							chunk_q <= {chunk_q[30:0], bit_in};
						end
					end else if (req_q && !avail && ended_q) begin
						req_q        <= 1'b0;
						res_value_q  <= '0;
						res_status_q <= STAT_EOS;
					end
				end
				BK_FETCH: begin
					cur_q   <= rd_q.data;
					bleft_q <= rd_q.nbits;
					head_q  <= head_inc;
					count_q <= count_q - QC_W'(1);
				end
				BK_CHUNK: begin
					if (shift_q < SHIFT_W'(VALUE_W)) begin
						acc_q <= acc_q | placed;
					end
					shift_q <= shift_new;
					sign_q  <= chunk_q[d5 - 5'd1];
					if (more) begin
						need_q  <= width_q;
						chunk_q <= '0;
					end
				end
				BK_FINISH: begin
					req_q        <= 1'b0;
					res_value_q  <= (acc_q | ext) & rw_mask;
					res_status_q <= STAT_OK;
				end
				default: ;
			endcase
		end
	end

	// Output register: holds one result while the back end moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= STAT_OK;
		end else if ((state_q == BK_EMIT) && emit_ok) begin
			out_valid_q  <= 1'b1;
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;

endmodule

### rtl/msb_first_bit_reader_vbr_top.sv
// An accepted input transaction is registered in the command queue before the back end sees it.
// In the back end, bytes and end marks pass through the idle and advance states; a read
// is paced by the shift loop, one bit per cycle between byte fetches, by a check state and
// a registered store read for each new byte, and by a chunk state for each VBR chunk.
// Reset: arst_n asynchronous, active low; clears pointers, counts, the pending read
// and output valid. Byte store contents stay unwritten; no clearing pass.
`timescale 1ns / 1ps

module msb_first_bit_reader_vbr_top import mbrv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata from bit 0: byte_value[7:0], byte_bits[11:8], read_mode[13:12],
	// read_width[20:14], wide_result[21], zero fill [23:22]
	input  logic [IN_DATA_W-1:0] s_tdata,
	// s_tuser: kind[1:0] (stream byte, read request, end of stream)
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata: value[63:0]
	output logic [VALUE_W-1:0]   m_tdata,
	// m_tuser: status[1:0] (ok, stream ended early, bad request)
	output logic [1:0]           m_tuser
);

	// Front end decodes each transaction (clamps byte_bits, aligns the byte,
	// checks request widths) and drops those that change nothing.
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;

	// Back end pops decoded transactions in order.
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	mbrv_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Two-entry queue so the front keeps accepting while the back end shifts bits.
	mbrv_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_cmd    (push_cmd),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_cmd   (pop_cmd)
	);

	// Back end: byte store, bit extraction MSB first, fixed and VBR assembly,
	// result register toward the master side.
	mbrv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### rtl/mbrv_checker.sv
`timescale 1ns / 1ps
`include "msb_first_bit_reader_vbr_top_macros.svh"

module mbrv_checker import mbrv_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [IN_DATA_W-1:0] s_tdata,
	input logic [1:0]           s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [VALUE_W-1:0]   m_tdata,
	input logic [1:0]           m_tuser
);

	// A stalled result holds.
	`MBRV_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// Only defined status codes leave the block.
	`MBRV_ASSERT(a_status_code, clk, arst_n, m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_EOS || m_tuser == STAT_BAD), "undefined status code")

	// Failed reads carry a zero value.
	`MBRV_ASSERT(a_fail_zero, clk, arst_n, m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0), "nonzero value on failed read")

	// No result is offered while reset is held.
	`MBRV_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind msb_first_bit_reader_vbr_top mbrv_checker u_mbrv_checker (.*);
